// ----- hw/rtl/lmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types and constants for the LED matrix frame scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfs_pkg;

    // Matrix geometry. ROWS may be 1 to 8; a row always holds eight columns.
    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int ROW_IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_IDX_W-1:0] ROW_LAST = ROW_IDX_W'(ROWS - 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        FUNC_PIXEL_ON  = 4'd0,
        FUNC_PIXEL_OFF = 4'd1,
        FUNC_ALL_ON    = 4'd2,
        FUNC_ALL_OFF   = 4'd3,
        FUNC_ROW_ON    = 4'd4,
        FUNC_ROW_OFF   = 4'd5,
        FUNC_COL_ON    = 4'd6,
        FUNC_COL_OFF   = 4'd7,
        FUNC_LOAD_ROW  = 4'd8,
        FUNC_REFRESH   = 4'd9
    } func_t;

    typedef struct packed {
        func_t          func;
        logic [2:0]     col;
        logic [2:0]     row;
        logic [COLS-1:0] bits;
    } cmd_t;

    // Push side of the command queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    // Pop side of the command queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lmfs_front.sv -----
// ----------------------------------------------------------------------------
// lmfs_front
// Accepts input words, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfs_front (
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [3:0]     func,
    input  wire logic [2:0]     col_index,
    input  wire logic [2:0]     row_index,
    input  wire logic [7:0]     row_bits,
    input  wire logic           q_full,
    output lmfs_pkg::q_wr_t     q_wr
);

    logic row_ok;
    logic keep;

    assign row_ok = ({1'b0, row_index} < 4'(lmfs_pkg::ROWS));

    always_comb
    begin
        case (lmfs_pkg::func_t'(func))
            lmfs_pkg::FUNC_PIXEL_ON,
            lmfs_pkg::FUNC_PIXEL_OFF,
            lmfs_pkg::FUNC_ROW_ON,
            lmfs_pkg::FUNC_ROW_OFF,
            lmfs_pkg::FUNC_LOAD_ROW:  keep = row_ok;
            lmfs_pkg::FUNC_ALL_ON,
            lmfs_pkg::FUNC_ALL_OFF,
            lmfs_pkg::FUNC_COL_ON,
            lmfs_pkg::FUNC_COL_OFF,
            lmfs_pkg::FUNC_REFRESH:   keep = 1'b1;
            default:                  keep = 1'b0;   // unused codes
        endcase
    end

    assign in_ready     = !q_full;
    assign q_wr.push    = in_valid && in_ready && keep;
    assign q_wr.cmd.func = lmfs_pkg::func_t'(func);
    assign q_wr.cmd.col  = col_index;
    assign q_wr.cmd.row  = row_index;
    assign q_wr.cmd.bits = row_bits;

endmodule

`default_nettype wire

// ----- hw/rtl/lmfs_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// lmfs_cmd_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfs_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lmfs_pkg::q_wr_t q_wr,
    output logic                q_full,
    output lmfs_pkg::q_rd_t     q_rd,
    input  wire logic           q_pop
);

    lmfs_pkg::cmd_t                 entry_reg [lmfs_pkg::QUEUE_DEPTH];
    logic [lmfs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lmfs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lmfs_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_pop;

    assign q_full    = (count_reg == lmfs_pkg::QCNT_W'(lmfs_pkg::QUEUE_DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == lmfs_pkg::QPTR_W'(lmfs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lmfs_pkg::QPTR_W'(lmfs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({q_wr.push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lmfs_back.sv -----
// ----------------------------------------------------------------------------
// lmfs_back
// Frame store, edit execution and row scan sequencer with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfs_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lmfs_pkg::q_rd_t       q_rd,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 column_drive,
    output logic [7:0]                 row_select,
    output logic                       last_row
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                              state_reg;
    logic [lmfs_pkg::ROW_IDX_W-1:0]      scan_cnt_reg;
    logic [lmfs_pkg::COLS-1:0]           frame_reg  [lmfs_pkg::ROWS];
    logic [lmfs_pkg::COLS-1:0]           frame_next [lmfs_pkg::ROWS];
    logic                                out_valid_reg;
    logic [7:0]                          column_drive_reg;
    logic [7:0]                          row_select_reg;
    logic                                last_row_reg;
    logic [lmfs_pkg::COLS-1:0]           colmask;
    logic                                out_free;

    assign colmask  = 8'b1 << q_rd.cmd.col;
    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_rd.valid;

    // Edit applied to every row in parallel; only hit rows change for row ops
    always_comb
    begin
        for (int r = 0; r < lmfs_pkg::ROWS; r++)
        begin
            logic hit;
            hit = (q_rd.cmd.row == 3'(r));
            frame_next[r] = frame_reg[r];
            case (q_rd.cmd.func)
                lmfs_pkg::FUNC_PIXEL_ON:  if (hit) frame_next[r] = frame_reg[r] | colmask;
                lmfs_pkg::FUNC_PIXEL_OFF: if (hit) frame_next[r] = frame_reg[r] & ~colmask;
                lmfs_pkg::FUNC_ALL_ON:    frame_next[r] = '1;
                lmfs_pkg::FUNC_ALL_OFF:   frame_next[r] = '0;
                lmfs_pkg::FUNC_ROW_ON:    if (hit) frame_next[r] = '1;
                lmfs_pkg::FUNC_ROW_OFF:   if (hit) frame_next[r] = '0;
                lmfs_pkg::FUNC_COL_ON:    frame_next[r] = frame_reg[r] | colmask;
                lmfs_pkg::FUNC_COL_OFF:   frame_next[r] = frame_reg[r] & ~colmask;
                lmfs_pkg::FUNC_LOAD_ROW:  if (hit) frame_next[r] = q_rd.cmd.bits;
                default:                  frame_next[r] = frame_reg[r];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
            column_drive_reg <= '0;
            row_select_reg   <= '0;
            last_row_reg     <= 1'b0;
            for (int r = 0; r < lmfs_pkg::ROWS; r++)
            begin
                frame_reg[r] <= '0;
            end
        end
        else
        begin
            // in scan the output register is reloaded whenever it frees up
            if (out_valid_reg && out_ready && (state_reg != ST_SCAN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_rd.valid)
                    begin
                        if (q_rd.cmd.func == lmfs_pkg::FUNC_REFRESH)
                        begin
                            scan_cnt_reg <= '0;
                            state_reg    <= ST_SCAN;
                        end
                        else
                        begin
                            frame_reg <= frame_next;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        column_drive_reg <= ~frame_reg[scan_cnt_reg];
                        row_select_reg   <= 8'b1 << scan_cnt_reg;
                        last_row_reg     <= (scan_cnt_reg == lmfs_pkg::ROW_LAST);
                        if (scan_cnt_reg == lmfs_pkg::ROW_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = column_drive_reg;
    assign row_select   = row_select_reg;
    assign last_row     = last_row_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/led_matrix_frame_scan_unit.sv -----
// ----------------------------------------------------------------------------
// led_matrix_frame_scan_unit
// 8x8 LED frame store with edit commands and row-by-row refresh output.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | func, col_index, row_index, row_bits
//  output  | out_valid / out_ready| column_drive, row_select, last_row
//
//  The back part applies an edit word as it dequeues it; a refresh is dequeued
//  and then drives the ROWS rows (8) in turn, set by the scan counter.
//  A two-entry command queue lets the front keep accepting while a scan runs.
//  Reset clears the frame store to all pixels off and empties the queue.
//  A stalled output holds the scan; edits queued behind a refresh wait for it.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_frame_scan_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  func,
    input  wire logic [2:0]  col_index,
    input  wire logic [2:0]  row_index,
    input  wire logic [7:0]  row_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       column_drive,
    output logic [7:0]       row_select,
    output logic             last_row
);

    lmfs_pkg::q_wr_t q_wr;
    lmfs_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            q_pop;

    lmfs_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .col_index (col_index),
        .row_index (row_index),
        .row_bits  (row_bits),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    lmfs_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .q_pop  (q_pop)
    );

    lmfs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd         (q_rd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_drive (column_drive),
        .row_select   (row_select),
        .last_row     (last_row)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_wr.push)
        else $error("command pushed into full queue");

    a_row_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(row_select))
        else $error("row select not one-hot");

    a_last_row_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_row == row_select[lmfs_pkg::ROWS-1]))
        else $error("last row flag does not match row select");

endmodule

`default_nettype wire
